/* src/sm_pkg.sv */
// shared constants, types and the exp table for the softmin row normalizer
// no dependencies
package sm_pkg;

    localparam int MAX_ROW     = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ELEM_W      = 16;
    localparam int PROB_W      = 16;
    localparam int IDX_W       = $clog2(MAX_ROW);
    localparam int CNT_W       = $clog2(MAX_ROW + 1);
    localparam int TOTAL_W     = 23;
    localparam int EXP_W       = 17;
    localparam int T_W         = 29;
    localparam int N_W         = T_W - 20;
    localparam int NUM_W       = SAMPLE_BITS + EXP_W + 1;
    localparam int DCNT_W      = $clog2(NUM_W + 1);
    localparam int SHR         = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
    localparam int SHL         = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam int QAL_W       = NUM_W + SHL;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QLVL_W      = $clog2(QDEPTH + 1);

    localparam logic [12:0] LOG2E_Q12 = 13'd5909;
    localparam logic signed [ELEM_W-1:0] MIN_RESET = 16'sd32767;

    typedef struct packed {
        logic signed [ELEM_W-1:0] row_min;
        logic [CNT_W-1:0]         count;
    } row_desc_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [ELEM_W-1:0] data;
        logic              push;
        row_desc_t         desc;
    } front_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MUL_D,
        BK_MUL_R,
        BK_EXP,
        BK_DIV,
        BK_PUSH
    } back_state_t;

    // 2^(-k/16) in q16
    function automatic logic [EXP_W-1:0] pow2_frac(input logic [4:0] k);
        logic [EXP_W-1:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

/* src/softmin_row_normalizer_top.sv */
// top level of the softmin row normalizer
// depends on sm_pkg, sm_front, sm_row_queue, sm_back

// Row-wise softmin in fixed point. Signed q8.8 elements arrive on the input
// stream one item per cycle, s_tlast on the last element of a row; up to 64
// elements per row are kept, further elements of an over-long row are dropped
// but their tlast still closes the row. Once a row is closed the block emits
// one unsigned q0.16 probability exp(min - x) / sum per stored element, in
// input order, with m_tlast on the last one; a probability of 1.0 reads 65535.
// Loading runs at one item per cycle. Two rows can be held: while the back end
// works on one, the next row is loaded, and input stalls only when both banks
// are full. For each element the back end reads, multiplies and takes the exp
// to add it to the row sum; in a second pass it does so again, then runs the
// bit-serial divider and pushes the probability. An output register lets the
// back end go on to the next element while a result waits.
// No clearing pass is needed after reset.
module softmin_row_normalizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // element_value
    input  logic        s_tlast,   // row_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // probability
    output logic        m_tlast    // row_done
);

    sm_pkg::front_wr_t          wr;
    sm_pkg::queue_status_t      q_status;
    sm_pkg::row_desc_t          head;
    logic [sm_pkg::ELEM_W-1:0]  rd_data;
    logic [sm_pkg::IDX_W-1:0]   rd_idx;
    logic                       pop;
    logic                       bk_busy;

    // accepts elements, keeps min and count of the open row
    sm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .wr       (wr)
    );

    // two row banks with their descriptors
    sm_row_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .pop     (pop),
        .rd_idx  (rd_idx),
        .head    (head),
        .rd_data (rd_data),
        .status  (q_status)
    );

    // exp, sum, divide and output
    sm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head     (head),
        .rd_data  (rd_data),
        .rd_idx   (rd_idx),
        .pop      (pop),
        .busy     (bk_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // the queue level can never read full and empty at once
    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty together");

    // the back end only works on a row that is held in the queue
    a_back_has_row: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_busy |-> !q_status.empty)
        else $error("back end busy with no row queued");

    // a row is never closed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.push |-> !q_status.full)
        else $error("row pushed into full queue");

    // a pop only happens while a row is held
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("row popped from empty queue");
`endif

endmodule

/* src/sm_front.sv */
// front end: accepts row elements, tracks the row minimum and count
// depends on sm_pkg
module sm_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sm_pkg::ELEM_W-1:0]  s_tdata,
    input  logic                       s_tlast,
    input  sm_pkg::queue_status_t      q_status,
    output sm_pkg::front_wr_t          wr
);

    logic signed [sm_pkg::ELEM_W-1:0] min_reg, min_next;
    logic [sm_pkg::CNT_W-1:0]         count_reg, count_next;
    logic                             accept;
    logic                             room;
    logic signed [sm_pkg::ELEM_W-1:0] x;

    assign x        = $signed(s_tdata);
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign room     = count_reg < sm_pkg::CNT_W'(sm_pkg::MAX_ROW);

    always_comb begin
        min_next   = (room && x < min_reg) ? x : min_reg;
        count_next = room ? count_reg + sm_pkg::CNT_W'(1) : count_reg;
    end

    always_comb begin
        wr.we           = accept && room;
        wr.idx          = count_reg[sm_pkg::IDX_W-1:0];
        wr.data         = s_tdata;
        wr.push         = accept && s_tlast;
        wr.desc.row_min = min_next;
        wr.desc.count   = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= sm_pkg::MIN_RESET;
            count_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                min_reg   <= sm_pkg::MIN_RESET;
                count_reg <= '0;
            end else begin
                min_reg   <= min_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

/* src/sm_row_queue.sv */
// two-row queue between front and back: row banks plus row descriptors
// depends on sm_pkg
module sm_row_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sm_pkg::front_wr_t          wr,
    input  logic                       pop,
    input  logic [sm_pkg::IDX_W-1:0]   rd_idx,
    output sm_pkg::row_desc_t          head,
    output logic [sm_pkg::ELEM_W-1:0]  rd_data,
    output sm_pkg::queue_status_t      status
);

    logic [sm_pkg::ELEM_W-1:0] mem [sm_pkg::QDEPTH*sm_pkg::MAX_ROW];
    sm_pkg::row_desc_t         desc_mem [sm_pkg::QDEPTH];
    logic [sm_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [sm_pkg::QLVL_W-1:0] level_reg;
    logic [sm_pkg::ELEM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[{wr_ptr_reg, wr.idx}] <= wr.data;
        end
        rd_data_reg <= mem[{rd_ptr_reg, rd_idx}];
        if (wr.push) begin
            desc_mem[wr_ptr_reg] <= wr.desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (wr.push) wr_ptr_reg <= wr_ptr_reg + sm_pkg::QPTR_W'(1);
            if (pop)     rd_ptr_reg <= rd_ptr_reg + sm_pkg::QPTR_W'(1);
            if (wr.push && !pop) begin
                level_reg <= level_reg + sm_pkg::QLVL_W'(1);
            end else if (pop && !wr.push) begin
                level_reg <= level_reg - sm_pkg::QLVL_W'(1);
            end
        end
    end

    assign head         = desc_mem[rd_ptr_reg];
    assign rd_data      = rd_data_reg;
    assign status.full  = level_reg == sm_pkg::QLVL_W'(sm_pkg::QDEPTH);
    assign status.empty = level_reg == '0;

endmodule

/* src/sm_back.sv */
// back end: exp of each element, row sum, bit-serial divide, output register
// depends on sm_pkg
module sm_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sm_pkg::queue_status_t      q_status,
    input  sm_pkg::row_desc_t          head,
    input  logic [sm_pkg::ELEM_W-1:0]  rd_data,
    output logic [sm_pkg::IDX_W-1:0]   rd_idx,
    output logic                       pop,
    output logic                       busy,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sm_pkg::PROB_W-1:0]  m_tdata,
    output logic                       m_tlast
);

    sm_pkg::back_state_t         state_reg, state_next;
    logic [sm_pkg::IDX_W-1:0]    idx_reg;
    logic                        div_pass_reg;
    logic [sm_pkg::TOTAL_W-1:0]  total_reg;
    logic [sm_pkg::T_W-1:0]      t_reg;
    logic [sm_pkg::EXP_W-1:0]    a_reg;
    logic [sm_pkg::N_W-1:0]      n_reg;
    logic [sm_pkg::EXP_W-1:0]    prod_reg;
    logic [sm_pkg::NUM_W-1:0]    num_reg;
    logic [sm_pkg::NUM_W-1:0]    quo_reg;
    logic [sm_pkg::TOTAL_W-1:0]  rem_reg;
    logic [sm_pkg::DCNT_W-1:0]   dcnt_reg;
    logic                        out_valid_reg;
    logic [sm_pkg::PROB_W-1:0]   out_data_reg;
    logic                        out_last_reg;

    logic signed [sm_pkg::ELEM_W:0] diff;
    logic [sm_pkg::T_W-1:0]         t_full;
    logic [3:0]                     k;
    logic [15:0]                    r;
    logic [sm_pkg::EXP_W-1:0]       ta, tb;
    logic [32:0]                    prod_full;
    logic [sm_pkg::EXP_W-1:0]       v;
    logic [4:0]                     shamt;
    logic [sm_pkg::EXP_W:0]         rnd, shifted;
    logic [sm_pkg::EXP_W-1:0]       e_val;
    logic                           last_elem;
    logic [sm_pkg::TOTAL_W:0]       rem_sh;
    logic                           ge;
    logic [sm_pkg::QAL_W-1:0]       q_al;
    logic [sm_pkg::PROB_W-1:0]      prob;
    logic                           out_free;
    logic                           div_done;

    // exp datapath
    always_comb begin
        diff   = $signed({rd_data[sm_pkg::ELEM_W-1], rd_data})
               - $signed({head.row_min[sm_pkg::ELEM_W-1], head.row_min});
        t_full = sm_pkg::T_W'(diff[sm_pkg::ELEM_W-1:0]) * sm_pkg::T_W'(sm_pkg::LOG2E_Q12);
        k      = t_reg[19:16];
        r      = t_reg[15:0];
        ta     = sm_pkg::pow2_frac({1'b0, k});
        tb     = sm_pkg::pow2_frac({1'b0, k} + 5'd1);
        prod_full = 33'(ta - tb) * 33'(r);
        v       = a_reg - prod_reg;
        shamt   = n_reg[4:0];
        rnd     = (sm_pkg::EXP_W+1)'(1) << (shamt - 5'd1);
        shifted = ((sm_pkg::EXP_W+1)'(v) + rnd) >> shamt;
        if (n_reg == '0) begin
            e_val = v;
        end else if (n_reg > sm_pkg::N_W'(17)) begin
            e_val = '0;
        end else begin
            e_val = shifted[sm_pkg::EXP_W-1:0];
        end
    end

    assign last_elem = (sm_pkg::CNT_W'(idx_reg) + sm_pkg::CNT_W'(1)) == head.count;

    // divider step and result alignment
    always_comb begin
        rem_sh   = {rem_reg, num_reg[sm_pkg::NUM_W-1]};
        ge       = rem_sh >= {1'b0, total_reg};
        div_done = dcnt_reg == sm_pkg::DCNT_W'(sm_pkg::NUM_W - 1);
        q_al     = sm_pkg::QAL_W'(quo_reg >> sm_pkg::SHR) << sm_pkg::SHL;
        if (total_reg == '0) begin
            prob = '0;
        end else if (|q_al[sm_pkg::QAL_W-1:sm_pkg::PROB_W]) begin
            prob = '1;
        end else begin
            prob = q_al[sm_pkg::PROB_W-1:0];
        end
        out_free = !out_valid_reg || m_tready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sm_pkg::BK_IDLE:  if (!q_status.empty) state_next = sm_pkg::BK_READ;
            sm_pkg::BK_READ:  state_next = sm_pkg::BK_MUL_D;
            sm_pkg::BK_MUL_D: state_next = sm_pkg::BK_MUL_R;
            sm_pkg::BK_MUL_R: state_next = sm_pkg::BK_EXP;
            sm_pkg::BK_EXP:   state_next = div_pass_reg ? sm_pkg::BK_DIV : sm_pkg::BK_READ;
            sm_pkg::BK_DIV:   if (div_done) state_next = sm_pkg::BK_PUSH;
            sm_pkg::BK_PUSH: begin
                if (out_free) state_next = last_elem ? sm_pkg::BK_IDLE : sm_pkg::BK_READ;
            end
            default:  state_next = sm_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop      = (state_reg == sm_pkg::BK_PUSH) && out_free && last_elem;
        busy     = state_reg != sm_pkg::BK_IDLE;
        rd_idx   = idx_reg;
        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
        m_tlast  = out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sm_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sm_pkg::BK_PUSH && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            sm_pkg::BK_IDLE: begin
                idx_reg      <= '0;
                div_pass_reg <= 1'b0;
                total_reg    <= '0;
            end
            sm_pkg::BK_READ: begin
            end
            sm_pkg::BK_MUL_D: begin
                t_reg <= t_full;
            end
            sm_pkg::BK_MUL_R: begin
                a_reg    <= ta;
                n_reg    <= t_reg[sm_pkg::T_W-1:20];
                prod_reg <= prod_full[32:16];
            end
            sm_pkg::BK_EXP: begin
                if (div_pass_reg) begin
                    num_reg  <= (sm_pkg::NUM_W'(e_val) << sm_pkg::SAMPLE_BITS)
                              + sm_pkg::NUM_W'(total_reg[sm_pkg::TOTAL_W-1:1]);
                    quo_reg  <= '0;
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                end else begin
                    total_reg <= total_reg + sm_pkg::TOTAL_W'(e_val);
                    if (last_elem) begin
                        idx_reg      <= '0;
                        div_pass_reg <= 1'b1;
                    end else begin
                        idx_reg <= idx_reg + sm_pkg::IDX_W'(1);
                    end
                end
            end
            sm_pkg::BK_DIV: begin
                rem_reg  <= ge ? sm_pkg::TOTAL_W'(rem_sh - {1'b0, total_reg})
                               : rem_sh[sm_pkg::TOTAL_W-1:0];
                num_reg  <= num_reg << 1;
                quo_reg  <= {quo_reg[sm_pkg::NUM_W-2:0], ge};
                dcnt_reg <= dcnt_reg + sm_pkg::DCNT_W'(1);
            end
            sm_pkg::BK_PUSH: begin
                if (out_free) begin
                    out_data_reg <= prob;
                    out_last_reg <= last_elem;
                    if (!last_elem) idx_reg <= idx_reg + sm_pkg::IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* tb/tb_softmin_row_normalizer_top.sv */
// testbench for the softmin row normalizer: random rows in, probabilities checked
// depends on sm_pkg and softmin_row_normalizer_top
`timescale 1ns / 100ps

module tb_softmin_row_normalizer_top;

    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
    } elem_item_t;

    typedef struct packed {
        logic [15:0] prob;
        logic        done;
    } prob_item_t;

    localparam int CYCLE_LIMIT = 900000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    elem_item_t  pending_elems[$];
    prob_item_t  expected_probs[$];

    // predictor copy of the row state
    logic signed [15:0] pred_row[sm_pkg::MAX_ROW];
    int                 pred_count = 0;
    int                 pred_min = 32767;

    int  mismatches = 0;
    int  results_seen = 0;
    int  rows_closed = 0;
    int  items_queued = 0;
    int  cycles = 0;
    bit  hold_sender = 1'b0;
    bit  calm = 1'b0;

    softmin_row_normalizer_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // exp(-d) with d in q8.8, result q16
    function automatic int unsigned neg_exp(int unsigned d);
        logic [16:0] lut[17];
        longint unsigned t, n, k, r, a, b, v;
        lut = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
                44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        t = longint'(d & 16'hFFFF) * 5909;
        n = t >> 20;
        k = (t >> 16) & 15;
        r = t & 16'hFFFF;
        a = lut[k];
        b = lut[k + 1];
        v = a - (((a - b) * r) >> 16);
        if (n == 0) return int'(v);
        if (n > 17) return 0;
        return int'((v + (64'd1 << (n - 1))) >> n);
    endfunction

    // accept one element; on row end queue the row's probabilities
    task automatic predict_elem(elem_item_t it);
        longint unsigned total, q;
        if (pred_count < sm_pkg::MAX_ROW) begin
            pred_row[pred_count] = it.value;
            if (int'(it.value) < pred_min) pred_min = it.value;
            pred_count++;
        end
        if (it.last) begin
            total = 0;
            for (int i = 0; i < pred_count; i++)
                total = (total + neg_exp(int'(pred_row[i]) - pred_min)) & 23'h7FFFFF;
            for (int i = 0; i < pred_count; i++) begin
                q = 0;
                if (total != 0) begin
                    q = ((longint'(neg_exp(int'(pred_row[i]) - pred_min))
                          << sm_pkg::SAMPLE_BITS) + (total >> 1)) / total;
                    if (sm_pkg::SAMPLE_BITS > 16) q = q >> sm_pkg::SHR;
                    else q = q << sm_pkg::SHL;
                    if (q > 65535) q = 65535;
                end
                expected_probs.push_back('{prob: q[15:0], done: (i == pred_count - 1)});
            end
            pred_count = 0;
            pred_min = 32767;
            rows_closed++;
        end
    endtask

    task automatic queue_row(int len, int mode);
        elem_item_t it;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: it.value = $urandom;
                1: it.value = $urandom_range(0, 1023) - 512;  // close values, spread probs
                default: it.value = $urandom_range(0, 7) * 16'sh1000;
            endcase
            it.last = (i == len - 1);
            pending_elems.push_back(it);
            items_queued++;
        end
    endtask

    // sender: one item per accepted handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_elem('{value: s_tdata, last: s_tlast});
                void'(pending_elems.pop_front());
            end
            if (!hold_sender && pending_elems.size() > 0
                    && (calm || $urandom_range(0, 99) >= 33)) begin
                elem_item_t nx;
                nx = pending_elems[0];
                if (!(s_tvalid && !s_tready)) begin
                    s_tdata <= nx.value;
                    s_tlast <= nx.last;
                end
                s_tvalid <= 1'b1;
            end else if (!(s_tvalid && !s_tready)) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_probs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result prob=%0d last=%0b", m_tdata, m_tlast);
                end else begin
                    prob_item_t ex;
                    ex = expected_probs.pop_front();
                    if (ex.prob !== m_tdata || ex.done !== m_tlast) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected prob=%0d last=%0b, got prob=%0d last=%0b",
                                     results_seen, ex.prob, ex.done, m_tdata, m_tlast);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, single element, full row, over-long row
        pending_elems.push_back('{value: 16'sh7FFF, last: 1'b1});
        pending_elems.push_back('{value: 16'sh8000, last: 1'b0});
        pending_elems.push_back('{value: 16'sh7FFF, last: 1'b1});
        pending_elems.push_back('{value: 16'sh0000, last: 1'b0});
        pending_elems.push_back('{value: 16'sh0000, last: 1'b0});
        pending_elems.push_back('{value: 16'shFFFF, last: 1'b1});
        pending_elems.push_back('{value: 16'sh5555, last: 1'b0});
        pending_elems.push_back('{value: 16'shAAAA, last: 1'b1});
        items_queued += 8;
        queue_row(sm_pkg::MAX_ROW, 1);
        queue_row(sm_pkg::MAX_ROW + 3, 0);   // last three dropped, tlast still closes

        // random rows, mostly short
        while (items_queued < 190) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            queue_row(len, $urandom_range(0, 2));
            if (items_queued > 160 && !calm) begin
                // pressure: drain completely before continuing
                wait (pending_elems.size() == 0);
                hold_sender = 1'b1;
                wait (expected_probs.size() == 0);
                @(posedge aclk);
                hold_sender = 1'b0;
                calm = 1'b1;   // stretch with no idling
                queue_row(20, 1);
                wait (pending_elems.size() == 0);
                calm = 1'b0;
            end
        end

        wait (pending_elems.size() == 0);
        wait (expected_probs.size() == 0);
        repeat (200) @(posedge aclk);
        $display("rows closed: %0d, probabilities checked: %0d", rows_closed, results_seen);
        $display("covered extremes, single and full rows, over-long rows, stalls on both sides");
        if (mismatches == 0 && expected_probs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* files.f */
src/sm_pkg.sv
src/sm_front.sv
src/sm_row_queue.sv
src/sm_back.sv
src/softmin_row_normalizer_top.sv
tb/tb_softmin_row_normalizer_top.sv
